/* hdl/fid_pkg.sv */
// ----------------------------------------------------------------------------
// fid_pkg
// Shared constants, status codes and control types of the floor integer
// divider.
// ----------------------------------------------------------------------------
package fid_pkg;

    // Default operand width of the divider core
    localparam int DIV_WIDTH = 32;

    // Fixed widths of the channel fields
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MOSTNEG = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture operand magnitudes, signs and status
        logic step;      // one restoring subtract-and-shift step
        logic fix;       // floor adjust of quotient and remainder
        logic out_load;  // final sign fix into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic err;       // captured item has a nonzero status
    } t_stat;

endpackage

/* hdl/fid_if.sv */
// ----------------------------------------------------------------------------
// fid_if
// Valid/ready channel interfaces of the divider: operand input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface fid_in_if;
    import fid_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fid_out_if;
    import fid_pkg::*;

    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  quotient;
    logic [FIELD_W-1:0]  remainder;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output quotient, output remainder, output status,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input status,
                    output ready);
endinterface

interface fid_cfg_if;
    logic valid;
    logic ready;
    logic signed_mode;

    modport source (output valid, output signed_mode, input ready);
    modport sink   (input valid, input signed_mode, output ready);
endinterface

/* hdl/floor_integer_divider_unit.sv */
// Sequence: an accepted item is loaded, then runs one restoring step per quotient bit,
// one floor fix-up and one output load; an error item skips the steps and the fix-up.
// The output load waits while an earlier result is not yet taken. One item at a time:
// the shared subtract-and-shift unit takes a new item only after the last is loaded.
// Reset (i_rst_n low, synchronous): controller idle, no result valid, unsigned mode.
// ----------------------------------------------------------------------------
// floor_integer_divider_unit
// Integer divider with unsigned truncating and signed floor division modes,
// returning quotient, remainder and a status code for each operand pair.
// ----------------------------------------------------------------------------
module floor_integer_divider_unit #(
    parameter int WIDTH = fid_pkg::DIV_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fid_in_if.sink     i_in,
    fid_out_if.source  o_out,
    fid_cfg_if.sink    i_cfg
);
    import fid_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Configuration is always taken
    assign i_cfg.ready = 1'b1;

    // Sequence the item
    fid_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Compute the result
    fid_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_signed_mode (i_cfg.signed_mode),
        .i_dividend        (i_in.dividend),
        .i_divisor         (i_in.divisor),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_quotient        (o_out.quotient),
        .o_remainder       (o_out.remainder),
        .o_status          (o_out.status)
    );

endmodule

/* hdl/fid_ctrl.sv */
// ----------------------------------------------------------------------------
// fid_ctrl
// Controller of the divider: sequences load, the restoring steps, the floor
// fix-up and the output register, and owns the result valid flag.
// ----------------------------------------------------------------------------
module fid_ctrl #(
    parameter int WIDTH = fid_pkg::DIV_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  fid_pkg::t_stat i_stat,
    output fid_pkg::t_cmd  o_cmd
);
    import fid_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode commands and the next state
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                n_cnt      = '0;
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_state = S_FIX;
                    end
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Set valid on a new result, drop it once the beat is taken
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state, step count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/fid_dpath.sv */
// ----------------------------------------------------------------------------
// fid_dpath
// Datapath of the divider: mode register, operand magnitudes, restoring
// remainder/quotient shift registers, floor fix-up and output register.
// ----------------------------------------------------------------------------
module fid_dpath #(
    parameter int WIDTH = fid_pkg::DIV_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_signed_mode,
    input  logic [fid_pkg::FIELD_W-1:0]      i_dividend,
    input  logic [fid_pkg::FIELD_W-1:0]      i_divisor,
    input  fid_pkg::t_cmd                    i_cmd,
    output fid_pkg::t_stat                   o_stat,
    output logic [fid_pkg::FIELD_W-1:0]      o_quotient,
    output logic [fid_pkg::FIELD_W-1:0]      o_remainder,
    output logic [fid_pkg::STATUS_W-1:0]     o_status
);
    import fid_pkg::*;

    localparam int EXT_W = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
    localparam logic [WIDTH-1:0] SIGN_BIT = {1'b1, {(WIDTH-1){1'b0}}};

    logic                r_signed_mode;
    logic [WIDTH-1:0]    r_quo;
    logic [WIDTH-1:0]    r_rem;
    logic [WIDTH-1:0]    r_mb;
    logic                r_na;
    logic                r_nb;
    logic [STATUS_W-1:0] r_status;
    logic [FIELD_W-1:0]  r_out_q;
    logic [FIELD_W-1:0]  r_out_r;
    logic [STATUS_W-1:0] r_out_st;

    logic [EXT_W-1:0]    a_ext, b_ext;
    logic [WIDTH-1:0]    a_w, b_w;
    logic                na, nb;
    logic [WIDTH-1:0]    ma, mb;
    logic [STATUS_W-1:0] status;
    logic [WIDTH:0]      shifted, diff;
    logic                adjust;
    logic [WIDTH-1:0]    q_fin, r_fin;
    logic [EXT_W-1:0]    q_ext, r_ext;

    // Keep the low WIDTH bits of each operand
    assign a_ext = EXT_W'(i_dividend);
    assign b_ext = EXT_W'(i_divisor);
    assign a_w   = a_ext[WIDTH-1:0];
    assign b_w   = b_ext[WIDTH-1:0];

    // Signs and magnitudes; signs count only in signed mode
    assign na = r_signed_mode && a_w[WIDTH-1];
    assign nb = r_signed_mode && b_w[WIDTH-1];
    assign ma = na ? (~a_w + 1'b1) : a_w;
    assign mb = nb ? (~b_w + 1'b1) : b_w;

    // Most-negative operand wins over the zero divisor
    always_comb begin
        priority if (r_signed_mode && (a_w == SIGN_BIT || b_w == SIGN_BIT)) begin
            status = ST_MOSTNEG;
        end else if (b_w == '0) begin
            status = ST_DIV0;
        end else begin
            status = ST_OK;
        end
    end

    // One restoring step: shift in the next dividend bit, trial subtract
    assign shifted = {r_rem, r_quo[WIDTH-1]};
    assign diff    = shifted - {1'b0, r_mb};

    // Round toward minus infinity when the signs differ
    assign adjust = (r_na != r_nb) && (r_rem != '0);

    // Final sign fix, zero on error
    assign q_fin = (r_status != ST_OK) ? '0 : ((r_na != r_nb) ? (~r_quo + 1'b1) : r_quo);
    assign r_fin = (r_status != ST_OK) ? '0 : (r_nb ? (~r_rem + 1'b1) : r_rem);
    assign q_ext = EXT_W'(q_fin);
    assign r_ext = EXT_W'(r_fin);

    assign o_stat.err  = (r_status != ST_OK);
    assign o_quotient  = r_out_q;
    assign o_remainder = r_out_r;
    assign o_status    = r_out_st;

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_signed_mode;
        end
    end

    // Advance the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo    <= ma;
            r_rem    <= '0;
            r_mb     <= mb;
            r_na     <= na;
            r_nb     <= nb;
            r_status <= status;
        end else if (i_cmd.step) begin
            if (!diff[WIDTH]) begin
                r_rem <= diff[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= shifted[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end else if (i_cmd.fix && adjust) begin
            r_rem <= r_mb - r_rem;
            r_quo <= r_quo + 1'b1;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_q  <= q_ext[FIELD_W-1:0];
            r_out_r  <= r_ext[FIELD_W-1:0];
            r_out_st <= r_status;
        end
    end

endmodule

/* hdl/fid_checker.sv */
// ----------------------------------------------------------------------------
// fid_checker
// Port-level assertions of the divider, bound to the top level.
// ----------------------------------------------------------------------------
module fid_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [fid_pkg::FIELD_W-1:0]      i_quotient,
    input logic [fid_pkg::FIELD_W-1:0]      i_remainder,
    input logic [fid_pkg::STATUS_W-1:0]     i_status
);
    import fid_pkg::*;

    // A result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before the beat was taken");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_quotient) && $stable(i_remainder) && $stable(i_status))
        else $error("stalled result payload changed");

    // Error results carry zero quotient and remainder
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_quotient == '0) && (i_remainder == '0))
        else $error("error result with nonzero quotient or remainder");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK) || (i_status == ST_DIV0)
                        || (i_status == ST_MOSTNEG))
        else $error("undefined status code");

    // Only one item in flight: no new accept right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

endmodule

bind floor_integer_divider_unit fid_checker u_fid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quotient  (o_out.quotient),
    .i_remainder (o_out.remainder),
    .i_status    (o_out.status)
);

/* tb/floor_integer_divider_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floor_integer_divider_unit_test
// Self-checking bench for the floor integer divider. A directed table covers
// the operand extremes, divide by zero and most-negative operands in both
// modes, then random operand pairs run in phases under both sign modes. Every
// result beat is checked field by field against an in-bench floor-division
// predictor, with random idle gaps on the operand side and random stalls on
// the result side, including one long result hold-off.
// ----------------------------------------------------------------------------
module floor_integer_divider_unit_test;
    import fid_pkg::*;

    localparam int DW            = DIV_WIDTH;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 84;
    localparam int HOLD_AT       = 60;   // result count that triggers the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = DW + 10;

    localparam logic [DW-1:0]      MOST_NEG   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [FIELD_W-1:0] F_MOST_NEG = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] F_MAX_POS  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [FIELD_W-1:0]  quotient;
        logic [FIELD_W-1:0]  remainder;
        logic [STATUS_W-1:0] status;
    } t_div_result;

    // One directed row: mode, operands, and a typed result where it is obvious
    typedef struct packed {
        logic                signed_sel;
        logic [FIELD_W-1:0]  dividend;
        logic [FIELD_W-1:0]  divisor;
        logic                typed;
        logic [FIELD_W-1:0]  quotient;
        logic [FIELD_W-1:0]  remainder;
        logic [STATUS_W-1:0] status;
    } t_div_case;

    localparam int N_DIRECTED = 25;
    localparam t_div_case DIRECTED [0:N_DIRECTED-1] = '{
        // unsigned mode, from the reset value of the mode register
        '{1'b0, 32'd7,          32'd2,          1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b0, 32'd100,        32'd0,          1'b1, 32'd0, 32'd0, ST_DIV0},
        '{1'b0, 32'd0,          32'd0,          1'b1, 32'd0, 32'd0, ST_DIV0},
        '{1'b0, 32'hFFFF_FFFF,  32'd1,          1'b1, 32'hFFFF_FFFF, 32'd0, ST_OK},
        '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1, 32'd0, ST_OK},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0, 32'd0, ST_OK},
        '{1'b0, 32'h8000_0000,  32'hFFFF_FFFF,  1'b1, 32'd0, 32'h8000_0000, ST_OK},
        '{1'b0, 32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b1, 32'd0, 32'hFFFF_FFFE, ST_OK},
        '{1'b0, 32'h1234_5678,  32'h0000_ABCD,  1'b0, 32'd0, 32'd0, ST_OK},
        // signed mode: most-negative operands win over a zero divisor
        '{1'b1, 32'h8000_0000,  32'd3,          1'b1, 32'd0, 32'd0, ST_MOSTNEG},
        '{1'b1, 32'd5,          32'h8000_0000,  1'b1, 32'd0, 32'd0, ST_MOSTNEG},
        '{1'b1, 32'h8000_0000,  32'd0,          1'b1, 32'd0, 32'd0, ST_MOSTNEG},
        '{1'b1, 32'h8000_0000,  32'h8000_0000,  1'b1, 32'd0, 32'd0, ST_MOSTNEG},
        '{1'b1, 32'd5,          32'd0,          1'b1, 32'd0, 32'd0, ST_DIV0},
        '{1'b1, 32'd0,          32'd0,          1'b1, 32'd0, 32'd0, ST_DIV0},
        // all four sign combinations, with and without a remainder
        '{1'b1, 32'd7,          32'd2,          1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'hFFFF_FFF9,  32'd2,          1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'd7,          32'hFFFF_FFFE,  1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'hFFFF_FFF9,  32'hFFFF_FFFE,  1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'd6,          32'hFFFF_FFFD,  1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'h7FFF_FFFF,  32'd1,          1'b1, 32'h7FFF_FFFF, 32'd0, ST_OK},
        '{1'b1, 32'h7FFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'h8000_0001, 32'd0, ST_OK},
        '{1'b1, 32'h8000_0001,  32'h7FFF_FFFF,  1'b1, 32'hFFFF_FFFF, 32'd0, ST_OK},
        '{1'b1, 32'hFFFF_FFFF,  32'h7FFF_FFFF,  1'b0, 32'd0, 32'd0, ST_OK},
        '{1'b1, 32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0, 32'd0, ST_OK}
    };

    logic i_clk;
    logic i_rst_n;

    fid_in_if  in_bus ();
    fid_out_if out_bus ();
    fid_cfg_if cfg_bus ();

    floor_integer_divider_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    t_div_result pending_quotients[$];
    logic        mode_shadow;
    int          mismatch_count;
    int          results_seen;

    // Floor division as the block defines it, on WIDTH-bit operands
    function automatic t_div_result floor_divide(logic [FIELD_W-1:0] dividend,
                                                 logic [FIELD_W-1:0] divisor,
                                                 logic signed_sel);
        logic [DW-1:0] a, b, mag_a, mag_b, uq, ur;
        logic          neg_a, neg_b;
        t_div_result   res;
        a   = DW'(dividend);
        b   = DW'(divisor);
        res = '0;
        res.status = ST_OK;
        if (signed_sel) begin
            if (a == MOST_NEG || b == MOST_NEG) begin
                res.status = ST_MOSTNEG;
            end else if (b == '0) begin
                res.status = ST_DIV0;
            end else begin
                neg_a = a[DW-1];
                neg_b = b[DW-1];
                mag_a = neg_a ? DW'('0 - a) : a;
                mag_b = neg_b ? DW'('0 - b) : b;
                uq = mag_a / mag_b;
                ur = mag_a % mag_b;
                // round toward minus infinity when the signs differ
                if (neg_a != neg_b) begin
                    if (ur != '0) begin
                        ur = mag_b - ur;
                        uq = uq + 1'b1;
                    end
                    uq = DW'('0 - uq);
                end
                if (neg_b) begin
                    ur = DW'('0 - ur);
                end
                res.quotient  = FIELD_W'(uq);
                res.remainder = FIELD_W'(ur);
            end
        end else if (b == '0) begin
            res.status = ST_DIV0;
        end else begin
            res.quotient  = FIELD_W'(a / b);
            res.remainder = FIELD_W'(a % b);
        end
        return res;
    endfunction

    // Operand mix: corner values, small magnitudes of both signs, shifted and full words
    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = 32'd1;
                    2:       v = '1;
                    3:       v = F_MOST_NEG;
                    4:       v = F_MAX_POS;
                    default: v = F_MOST_NEG + 1'b1;
                endcase
            end
            1:       v = $urandom_range(0, 15);
            2:       v = '0 - $urandom_range(1, 15);
            3, 4:    v = $urandom >> $urandom_range(1, 31);
            5:       v = '0 - ($urandom >> $urandom_range(1, 31));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int next_gap(bit no_gaps);
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Offer one operand beat, queue its result on acceptance, then idle a while
    task automatic send_operands(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor,
                                 t_div_result expected, bit no_gaps);
        int gap;
        in_bus.valid    <= 1'b1;
        in_bus.dividend <= dividend;
        in_bus.divisor  <= divisor;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_quotients.push_back(expected);
        gap = next_gap(no_gaps);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write the mode register once every outstanding result has drained
    task automatic set_signed_mode(logic signed_sel);
        in_bus.valid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge i_clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.signed_mode <= signed_sel;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        mode_shadow = signed_sel;
    endtask

    task automatic note_mismatch(string field, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: result %0d %s mismatch: expected %h, got %h",
                     $realtime, results_seen, field, want, got);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check each beat, stall at random, hold off once for a long stretch
    initial begin
        t_div_result want;
        int          stall_left;
        int          steady_left;
        int          pick;
        bit          hold_done;
        stall_left    = 0;
        steady_left   = 0;
        hold_done     = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                results_seen++;
                if (pending_quotients.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result beat with nothing pending: q %h r %h st %h",
                                 $realtime, out_bus.quotient, out_bus.remainder,
                                 out_bus.status);
                    end
                end else begin
                    want = pending_quotients.pop_front();
                    if (out_bus.quotient !== want.quotient)
                        note_mismatch("quotient", want.quotient, out_bus.quotient);
                    if (out_bus.remainder !== want.remainder)
                        note_mismatch("remainder", want.remainder, out_bus.remainder);
                    if (out_bus.status !== want.status)
                        note_mismatch("status", FIELD_W'(want.status), FIELD_W'(out_bus.status));
                end
            end
            if (!hold_done && results_seen == HOLD_AT) begin
                // long back-pressure: the operand side keeps offering meanwhile
                hold_done = 1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                out_bus.ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    stall_left = $urandom_range(0, 3);
                    out_bus.ready <= 1'b0;
                end else if (pick < 11) begin
                    stall_left = $urandom_range(10, 60);
                    out_bus.ready <= 1'b0;
                end else if (pick < 14) begin
                    steady_left = $urandom_range(50, 200);
                    out_bus.ready <= 1'b1;
                end else begin
                    out_bus.ready <= 1'b1;
                end
            end
        end
    end

    // Operand side and configuration: reset, directed table, random phases, drain
    initial begin
        t_div_case          row;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
        logic               phase_mode [0:RANDOM_PHASES-1];
        mismatch_count      = 0;
        results_seen        = 0;
        mode_shadow         = 1'b0;
        phase_mode          = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        i_rst_n            <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.dividend    <= '0;
        in_bus.divisor     <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.signed_mode <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; the first ones rely on the reset value of the mode
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.signed_sel != mode_shadow)
                set_signed_mode(row.signed_sel);
            if (row.typed)
                send_operands(row.dividend, row.divisor,
                              '{row.quotient, row.remainder, row.status}, 1'b0);
            else
                send_operands(row.dividend, row.divisor,
                              floor_divide(row.dividend, row.divisor, mode_shadow), 1'b0);
        end

        // random phases, every one starting with a register write
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_signed_mode(phase_mode[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                dividend = pick_operand();
                divisor  = pick_operand();
                send_operands(dividend, divisor, floor_divide(dividend, divisor, mode_shadow),
                              p[0]);
            end
        end
        in_bus.valid <= 1'b0;

        // drain, then keep watching for stray beats before the verdict
        while (pending_quotients.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
